// ===== rtl/core/rrp_pkg.sv =====
// Shared constants for the range and range-rate predictor.
package rrp_pkg;

	localparam int TAG_W    = 8;
	localparam int BIAS_W   = 32;
	localparam int OUT_W    = 40;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RX_POS_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RX_POS_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RX_POS_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RX_VEL_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RX_VEL_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RX_VEL_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLK_BIAS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CLK_DRIFT = 3'd7;

	localparam logic signed [OUT_W-1:0] OUT_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== rtl/core/rrp_isqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
module rrp_isqrt #(
	parameter int RADW  = 82,
	parameter int ROOTW = 41,
	parameter int SBW   = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [RADW-1:0]  rad,
	input  logic [SBW-1:0]   in_sb,
	output logic             out_vld,
	output logic [ROOTW-1:0] root,
	output logic [SBW-1:0]   out_sb
);

	localparam int TW = RADW + 1;

	logic             vld_s  [ROOTW];
	logic [TW-1:0]    rem_s  [ROOTW];
	logic [ROOTW-1:0] root_s [ROOTW];
	logic [SBW-1:0]   sb_s   [ROOTW];

	for (genvar k = 0; k < ROOTW; k++) begin : g_stage
		localparam int B = ROOTW - 1 - k;
		logic             vin;
		logic [TW-1:0]    rem_in;
		logic [ROOTW-1:0] root_in;
		logic [SBW-1:0]   sb_in;
		logic [TW-1:0]    trial;

		if (k == 0) begin : g_first
			assign vin     = in_vld;
			assign rem_in  = TW'(rad);
			assign root_in = '0;
			assign sb_in   = in_sb;
		end else begin : g_next
			assign vin     = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign sb_in   = sb_s[k-1];
		end

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_in;
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= root_in | (ROOTW'(1) << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	assign out_vld = vld_s[ROOTW-1];
	assign root    = root_s[ROOTW-1];
	assign out_sb  = sb_s[ROOTW-1];

endmodule

// ===== rtl/core/rrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rrp_div #(
	parameter int NUMW = 77,
	parameter int DENW = 42,
	parameter int QUOW = 34,
	parameter int SBW  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	input  logic [SBW-1:0]  in_sb,
	output logic            out_vld,
	output logic [QUOW-1:0] quo,
	output logic [SBW-1:0]  out_sb
);

	localparam int TW = (DENW + QUOW > NUMW) ? DENW + QUOW : NUMW;

	logic            vld_s [QUOW];
	logic [TW-1:0]   rem_s [QUOW];
	logic [DENW-1:0] den_s [QUOW];
	logic [QUOW-1:0] quo_s [QUOW];
	logic [SBW-1:0]  sb_s  [QUOW];

	for (genvar k = 0; k < QUOW; k++) begin : g_stage
		localparam int B = QUOW - 1 - k;
		logic            vin;
		logic [TW-1:0]   rem_in;
		logic [DENW-1:0] den_in;
		logic [QUOW-1:0] quo_in;
		logic [SBW-1:0]  sb_in;
		logic [TW-1:0]   trial;

		if (k == 0) begin : g_first
			assign vin    = in_vld;
			assign rem_in = TW'(num);
			assign den_in = den;
			assign quo_in = '0;
			assign sb_in  = in_sb;
		end else begin : g_next
			assign vin    = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign sb_in  = sb_s[k-1];
		end

		assign trial = TW'(den_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k]  <= sb_in;
				den_s[k] <= den_in;
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					quo_s[k] <= quo_in | (QUOW'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	assign out_vld = vld_s[QUOW-1];
	assign quo     = quo_s[QUOW-1];
	assign out_sb  = sb_s[QUOW-1];

endmodule

// ===== rtl/core/gnss_range_rate_predictor.sv =====
// Top level: predicts pseudorange and range rate for one satellite per word.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | sat_tag, sat_pos_x/y/z, sat_vel_x/y/z, sat_bias
//  out     | output    | out_valid/out_stall| out_tag, predicted_range, predicted_rate, saturated
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  A new word enters every cycle while in_stall is low. The pipeline holds five
//  stages of differences and partial products, one square-root stage per range
//  bit, one stage to form the dividend, one divider stage per quotient bit, one
//  sum stage and the output register.
//  Reset empties the pipeline and clears all configuration registers.
//  While a result waits under out_stall the whole pipeline holds and in_stall is high.
module gnss_range_rate_predictor #(
	parameter int POS_WIDTH = 40,
	parameter int VEL_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rrp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [((POS_WIDTH > VEL_WIDTH) ? POS_WIDTH : VEL_WIDTH)-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rrp_pkg::TAG_W-1:0]           sat_tag,
	input  logic signed [POS_WIDTH-1:0]         sat_pos_x,
	input  logic signed [POS_WIDTH-1:0]         sat_pos_y,
	input  logic signed [POS_WIDTH-1:0]         sat_pos_z,
	input  logic signed [VEL_WIDTH-1:0]         sat_vel_x,
	input  logic signed [VEL_WIDTH-1:0]         sat_vel_y,
	input  logic signed [VEL_WIDTH-1:0]         sat_vel_z,
	input  logic signed [rrp_pkg::BIAS_W-1:0]   sat_bias,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rrp_pkg::TAG_W-1:0]           out_tag,
	output logic signed [rrp_pkg::OUT_W-1:0]    predicted_range,
	output logic signed [rrp_pkg::OUT_W-1:0]    predicted_rate,
	output logic                                saturated
);

	import rrp_pkg::*;

	localparam int P    = POS_WIDTH;
	localparam int V    = VEL_WIDTH;
	localparam int DW   = P + 1;
	localparam int VW   = V + 1;
	localparam int H    = (DW + 1) / 2;
	localparam int HB   = DW - H;
	localparam int SQW  = 2 * DW;
	localparam int RW   = DW;
	localparam int PVW  = DW + VW;
	localparam int DOTW = PVW + 1;
	localparam int NW   = DOTW + 1;
	localparam int QW   = V + 2;
	localparam int PRW  = (P + 3 > OUT_W + 1) ? P + 3 : OUT_W + 1;
	localparam int RRW  = (V + 4 > OUT_W + 1) ? V + 4 : OUT_W + 1;
	localparam int SB1W = TAG_W + BIAS_W + DOTW;
	localparam int SB2W = TAG_W + BIAS_W + RW + 2;

	logic en;

	// configuration
	logic signed [P-1:0] rx_pos_q [3];
	logic signed [V-1:0] rx_vel_q [3];
	logic signed [P-1:0] clk_bias_q;
	logic signed [V-1:0] clk_drift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_pos_q[0] <= '0;
			rx_pos_q[1] <= '0;
			rx_pos_q[2] <= '0;
			rx_vel_q[0] <= '0;
			rx_vel_q[1] <= '0;
			rx_vel_q[2] <= '0;
			clk_bias_q  <= '0;
			clk_drift_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RX_POS_X:  rx_pos_q[0] <= cfg_data[P-1:0];
				REG_RX_POS_Y:  rx_pos_q[1] <= cfg_data[P-1:0];
				REG_RX_POS_Z:  rx_pos_q[2] <= cfg_data[P-1:0];
				REG_RX_VEL_X:  rx_vel_q[0] <= cfg_data[V-1:0];
				REG_RX_VEL_Y:  rx_vel_q[1] <= cfg_data[V-1:0];
				REG_RX_VEL_Z:  rx_vel_q[2] <= cfg_data[V-1:0];
				REG_CLK_BIAS:  clk_bias_q  <= cfg_data[P-1:0];
				REG_CLK_DRIFT: clk_drift_q <= cfg_data[V-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic signed [P-1:0] sp [3];
	logic signed [V-1:0] sv [3];
	assign sp[0] = sat_pos_x;
	assign sp[1] = sat_pos_y;
	assign sp[2] = sat_pos_z;
	assign sv[0] = sat_vel_x;
	assign sv[1] = sat_vel_y;
	assign sv[2] = sat_vel_z;

	// stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic signed [BIAS_W-1:0] bias_s1, bias_s2, bias_s3, bias_s4, bias_s5, bias_s6;

	logic signed [DW-1:0] d_s1 [3];
	logic signed [VW-1:0] v_s1 [3];
	logic [DW-1:0]        dm_s2 [3];
	logic [VW-1:0]        vm_s2 [3];
	logic                 sg_s2 [3], sg_s3 [3], sg_s4 [3];
	logic [2*H-1:0]       ll_s3 [3];
	logic [DW-1:0]        lh_s3 [3];
	logic [2*HB-1:0]      hh_s3 [3];
	logic [VW+H-1:0]      vl_s3 [3];
	logic [VW+HB-1:0]     vh_s3 [3];
	logic [SQW-1:0]       sq_s4 [3];
	logic [PVW-1:0]       pv_s4 [3];
	logic [SQW-1:0]       sumsq_s5;
	logic signed [DOTW-1:0] dot_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= sat_tag;
			bias_s1 <= sat_bias;
			tag_s2  <= tag_s1;
			bias_s2 <= bias_s1;
			tag_s3  <= tag_s2;
			bias_s3 <= bias_s2;
			tag_s4  <= tag_s3;
			bias_s4 <= bias_s3;
			tag_s5  <= tag_s4;
			bias_s5 <= bias_s4;
			for (int a = 0; a < 3; a++) begin
				// range vector and relative velocity
				d_s1[a] <= DW'(sp[a]) - DW'(rx_pos_q[a]);
				v_s1[a] <= VW'(sv[a]) - VW'(rx_vel_q[a]);
				dm_s2[a] <= d_s1[a][DW-1] ? DW'(-d_s1[a]) : DW'(d_s1[a]);
				vm_s2[a] <= v_s1[a][VW-1] ? VW'(-v_s1[a]) : VW'(v_s1[a]);
				sg_s2[a] <= d_s1[a][DW-1] ^ v_s1[a][VW-1];
				// partial products on split range magnitude
				ll_s3[a] <= dm_s2[a][H-1:0] * dm_s2[a][H-1:0];
				lh_s3[a] <= dm_s2[a][H-1:0] * dm_s2[a][DW-1:H];
				hh_s3[a] <= dm_s2[a][DW-1:H] * dm_s2[a][DW-1:H];
				vl_s3[a] <= vm_s2[a] * dm_s2[a][H-1:0];
				vh_s3[a] <= vm_s2[a] * dm_s2[a][DW-1:H];
				sg_s3[a] <= sg_s2[a];
				sq_s4[a] <= (SQW'(hh_s3[a]) << (2 * H)) + (SQW'(lh_s3[a]) << (H + 1))
					+ SQW'(ll_s3[a]);
				pv_s4[a] <= (PVW'(vh_s3[a]) << H) + PVW'(vl_s3[a]);
				sg_s4[a] <= sg_s3[a];
			end
			sumsq_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			dot_s5   <= (sg_s4[0] ? -signed'(DOTW'(pv_s4[0])) : signed'(DOTW'(pv_s4[0])))
				+ (sg_s4[1] ? -signed'(DOTW'(pv_s4[1])) : signed'(DOTW'(pv_s4[1])))
				+ (sg_s4[2] ? -signed'(DOTW'(pv_s4[2])) : signed'(DOTW'(pv_s4[2])));
		end
	end

	// square root of the squared range
	logic            sq_vld;
	logic [RW-1:0]   sq_root;
	logic [SB1W-1:0] sq_sb;

	rrp_isqrt #(
		.RADW  (SQW),
		.ROOTW (RW),
		.SBW   (SB1W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.rad     (sumsq_s5),
		.in_sb   ({tag_s5, bias_s5, dot_s5}),
		.out_vld (sq_vld),
		.root    (sq_root),
		.out_sb  (sq_sb)
	);

	logic [TAG_W-1:0]         sq_tag;
	logic signed [BIAS_W-1:0] sq_bias;
	logic signed [DOTW-1:0]   sq_dot;
	logic [DOTW-1:0]          sq_adot;
	assign {sq_tag, sq_bias, sq_dot} = sq_sb;
	assign sq_adot = sq_dot[DOTW-1] ? DOTW'(-sq_dot) : DOTW'(sq_dot);

	logic [NW-1:0] num_s6;
	logic [RW:0]   den_s6;
	logic [RW-1:0] range_s6;
	logic          neg_s6, zero_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sq_vld;
		end
	end

	// round to nearest: (2|dot| + r) / 2r
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s6   <= sq_tag;
			bias_s6  <= sq_bias;
			range_s6 <= sq_root;
			neg_s6   <= sq_dot[DOTW-1];
			zero_s6  <= (sq_root == '0);
			num_s6   <= (NW'(sq_adot) << 1) + NW'(sq_root);
			den_s6   <= {sq_root, 1'b0};
		end
	end

	logic            dv_vld;
	logic [QW-1:0]   dv_quo;
	logic [SB2W-1:0] dv_sb;

	rrp_div #(
		.NUMW (NW),
		.DENW (RW + 1),
		.QUOW (QW),
		.SBW  (SB2W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num     (num_s6),
		.den     (den_s6),
		.in_sb   ({tag_s6, bias_s6, range_s6, neg_s6, zero_s6}),
		.out_vld (dv_vld),
		.quo     (dv_quo),
		.out_sb  (dv_sb)
	);

	logic [TAG_W-1:0]         dv_tag;
	logic signed [BIAS_W-1:0] dv_bias;
	logic [RW-1:0]            dv_range;
	logic                     dv_neg, dv_zero;
	logic signed [RW:0]       dv_range_sx;
	logic signed [QW:0]       dv_mag;
	logic signed [QW:0]       dv_proj;
	assign {dv_tag, dv_bias, dv_range, dv_neg, dv_zero} = dv_sb;
	assign dv_range_sx = {1'b0, dv_range};
	assign dv_mag      = {1'b0, dv_quo};
	// coincident satellite: drop the projected term
	assign dv_proj = dv_zero ? '0 : (dv_neg ? -dv_mag : dv_mag);

	logic signed [PRW-1:0] pr_s7;
	logic signed [RRW-1:0] rr_s7;
	logic                  zero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s7  <= dv_tag;
			zero_s7 <= dv_zero;
			pr_s7   <= PRW'(dv_range_sx) + PRW'(dv_bias) + PRW'(clk_bias_q);
			rr_s7   <= RRW'(dv_proj) - RRW'(clk_drift_q);
		end
	end

	// clip to the output width
	logic                    pr_ovf, rr_ovf;
	logic signed [OUT_W-1:0] pr_clip, rr_clip;
	assign pr_ovf  = !((&pr_s7[PRW-1:OUT_W-1]) || !(|pr_s7[PRW-1:OUT_W-1]));
	assign rr_ovf  = !((&rr_s7[RRW-1:OUT_W-1]) || !(|rr_s7[RRW-1:OUT_W-1]));
	assign pr_clip = pr_ovf ? (pr_s7[PRW-1] ? OUT_NEG_LIM : OUT_POS_LIM) : pr_s7[OUT_W-1:0];
	assign rr_clip = rr_ovf ? (rr_s7[RRW-1] ? OUT_NEG_LIM : OUT_POS_LIM) : rr_s7[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag         <= tag_s7;
			predicted_range <= pr_clip;
			predicted_rate  <= rr_clip;
			saturated       <= pr_ovf || rr_ovf;
		end
	end

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (predicted_range == OUT_POS_LIM)
			|| (predicted_range == OUT_NEG_LIM) || (predicted_rate == OUT_POS_LIM)
			|| (predicted_rate == OUT_NEG_LIM))
		else $error("saturated flag without a clipped prediction");

	a_zero_range_rate: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && zero_s7 |-> rr_s7 == -RRW'(clk_drift_q))
		else $error("coincident satellite rate is not the negated drift");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && !vld_s7 && !vld_s6)
		else $error("pipeline not empty after reset");

endmodule
